// File: rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and the stop-word table of the tokenizer.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int STOP_COUNT = 127;
  localparam int WORD_CHARS = 10;
  localparam int LEN_W      = 7;

  typedef struct packed {
    logic             we;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
    logic             push;
    logic [LEN_W-1:0] push_len;
    logic             push_trunc;
  } buf_wr_t;

  function automatic logic [8*WORD_CHARS-1:0] stop_word(input int k);
    logic [8*WORD_CHARS-1:0] w;
    case (k)
      0: w = "a";          1: w = "about";      2: w = "above";      3: w = "after";
      4: w = "again";      5: w = "against";    6: w = "all";        7: w = "am";
      8: w = "an";         9: w = "and";        10: w = "any";       11: w = "are";
      12: w = "as";        13: w = "at";        14: w = "be";        15: w = "because";
      16: w = "been";      17: w = "before";    18: w = "being";     19: w = "below";
      20: w = "between";   21: w = "both";      22: w = "but";       23: w = "by";
      24: w = "cannot";    25: w = "could";     26: w = "did";       27: w = "do";
      28: w = "does";      29: w = "doing";     30: w = "down";      31: w = "during";
      32: w = "each";      33: w = "few";       34: w = "for";       35: w = "from";
      36: w = "further";   37: w = "get";       38: w = "got";       39: w = "had";
      40: w = "has";       41: w = "have";      42: w = "having";    43: w = "he";
      44: w = "her";       45: w = "here";      46: w = "hers";      47: w = "herself";
      48: w = "him";       49: w = "himself";   50: w = "his";       51: w = "how";
      52: w = "i";         53: w = "if";        54: w = "in";        55: w = "into";
      56: w = "is";        57: w = "it";        58: w = "its";       59: w = "itself";
      60: w = "me";        61: w = "more";      62: w = "most";      63: w = "my";
      64: w = "myself";    65: w = "no";        66: w = "nor";       67: w = "not";
      68: w = "of";        69: w = "off";       70: w = "on";        71: w = "once";
      72: w = "only";      73: w = "or";        74: w = "other";     75: w = "ought";
      76: w = "our";       77: w = "ours";      78: w = "ourselves"; 79: w = "out";
      80: w = "over";      81: w = "own";       82: w = "same";      83: w = "she";
      84: w = "should";    85: w = "so";        86: w = "some";      87: w = "such";
      88: w = "than";      89: w = "that";      90: w = "the";       91: w = "their";
      92: w = "theirs";    93: w = "them";      94: w = "themselves"; 95: w = "then";
      96: w = "there";     97: w = "these";     98: w = "they";      99: w = "this";
      100: w = "those";    101: w = "through";  102: w = "to";       103: w = "too";
      104: w = "under";    105: w = "until";    106: w = "up";       107: w = "very";
      108: w = "was";      109: w = "we";       110: w = "were";     111: w = "what";
      112: w = "when";     113: w = "where";    114: w = "which";    115: w = "while";
      116: w = "who";      117: w = "whom";     118: w = "why";      119: w = "will";
      120: w = "with";     121: w = "would";    122: w = "you";      123: w = "your";
      124: w = "yours";    125: w = "yourself"; 126: w = "yourselves";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] stop_len(input int k);
    logic [8*WORD_CHARS-1:0] w;
    logic [3:0]              n;
    w = stop_word(k);
    n = '0;
    for (int j = 0; j < WORD_CHARS; j++) begin
      if (w[8*j +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] stop_char(input int k, input logic [LEN_W-1:0] p);
    logic [8*WORD_CHARS-1:0] w;
    logic [3:0]              l;
    logic [7:0]              c;
    w = stop_word(k);
    l = stop_len(k);
    c = 8'd0;
    for (int j = 0; j < WORD_CHARS; j++) begin
      if (p == LEN_W'(j) && j < int'(l)) c = w[8*(int'(l)-1-j) +: 8];
    end
    return c;
  endfunction

endpackage

// File: rtl/core/tts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_in_if / tts_out_if
// Valid/ready channels for text bytes in and token bytes out.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       token_last;
  logic       token_truncated;
  modport source (output valid, output token_byte, output token_last,
                  output token_truncated, input ready);
  modport sink   (input valid, input token_byte, input token_last,
                  input token_truncated, output ready);
endinterface

// File: rtl/core/tts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_front
// Classifies text bytes, gathers tokens and tracks stop-word candidates.
// ----------------------------------------------------------------------------
module tts_front #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  input  logic               full_i,
  output logic               ready_o,
  output tts_pkg::buf_wr_t   wr_o
);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

  logic [LW-1:0]                  len_q, len_d, len_eff;
  logic                           ovf_q, ovf_d, ovf_eff;
  logic [tts_pkg::STOP_COUNT-1:0] match_q, match_d, match_eff;
  logic                           bank_q, bank_d;
  logic                           fire, is_tok, tok_wr, flush, stop, push;
  logic [7:0]                     v;

  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;

  always_comb begin
    v      = text_byte_i;
    is_tok = 1'b0;
    if (text_byte_i >= 8'h80) begin
      is_tok = 1'b1;
    end else if (text_byte_i >= "A" && text_byte_i <= "Z") begin
      v      = text_byte_i + 8'h20;
      is_tok = 1'b1;
    end else if ((text_byte_i >= "a" && text_byte_i <= "z") ||
                 (text_byte_i >= "0" && text_byte_i <= "9")) begin
      is_tok = 1'b1;
    end
  end

  always_comb begin
    tok_wr  = fire && is_tok && (len_q < LW'(MAX_TOKEN_LEN));
    len_eff = len_q + LW'(tok_wr);
    ovf_eff = ovf_q || (fire && is_tok && (len_q == LW'(MAX_TOKEN_LEN)));
    flush   = fire && (!is_tok || end_of_text_i);
    stop    = 1'b0;
    for (int k = 0; k < tts_pkg::STOP_COUNT; k++) begin
      match_eff[k] = match_q[k] &&
                     (!tok_wr || tts_pkg::stop_char(k, tts_pkg::LEN_W'(len_q)) == v);
      if (match_eff[k] && tts_pkg::LEN_W'(len_eff) == tts_pkg::LEN_W'(tts_pkg::stop_len(k)))
        stop = 1'b1;
    end
    stop = stop && !ovf_eff;
    push = flush && (len_eff != '0) && !stop;
  end

  always_comb begin
    len_d   = len_eff;
    ovf_d   = ovf_eff;
    match_d = match_eff;
    bank_d  = bank_q;
    if (flush) begin
      len_d   = '0;
      ovf_d   = 1'b0;
      match_d = '1;
      if (push) bank_d = !bank_q;
    end
  end

  always_comb begin
    wr_o.we         = tok_wr;
    wr_o.bank       = bank_q;
    wr_o.idx        = tts_pkg::LEN_W'(len_q);
    wr_o.data       = v;
    wr_o.push       = push;
    wr_o.push_len   = tts_pkg::LEN_W'(len_eff);
    wr_o.push_trunc = ovf_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      match_q <= '1;
      bank_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      match_q <= match_d;
      bank_q  <= bank_d;
    end
  end
endmodule

// File: rtl/core/tts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_back
// Two-bank token buffer with a descriptor queue and the byte emitter.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tts_pkg::buf_wr_t wr_i,
  output logic             full_o,
  input  logic             ready_i,
  output logic             valid_o,
  output logic [7:0]       token_byte_o,
  output logic             token_last_o,
  output logic             token_truncated_o
);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IW = $clog2(MAX_TOKEN_LEN);
  localparam int AW = $clog2(2 * MAX_TOKEN_LEN);

  logic [7:0]    mem_q [2*MAX_TOKEN_LEN];
  logic [LW-1:0] dlen_q [2];
  logic          dtrunc_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          head_q, head_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          ov_q, ov_d;
  logic [7:0]    rd_q;
  logic          last_q, trunc_q;
  logic          issue, rd_last;
  logic [AW-1:0] wr_addr, rd_addr;

  assign full_o  = (cnt_q == 2'd2);
  assign issue   = (cnt_q != 2'd0) && (!ov_q || ready_i);
  assign rd_last = (LW'(idx_q) + LW'(1)) == dlen_q[head_q];
  assign wr_addr = wr_i.bank ? AW'(MAX_TOKEN_LEN) + AW'(wr_i.idx[IW-1:0])
                             : AW'(wr_i.idx[IW-1:0]);
  assign rd_addr = head_q ? AW'(MAX_TOKEN_LEN) + AW'(idx_q) : AW'(idx_q);

  always_comb begin
    cnt_d  = cnt_q + 2'(wr_i.push) - 2'(issue && rd_last);
    head_d = head_q;
    idx_d  = idx_q;
    if (issue) begin
      if (rd_last) begin
        head_d = !head_q;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end
    ov_d = issue ? 1'b1 : (ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_addr] <= wr_i.data;
    if (wr_i.push) begin
      dlen_q[wr_i.bank]   <= LW'(wr_i.push_len);
      dtrunc_q[wr_i.bank] <= wr_i.push_trunc;
    end
    if (issue) begin
      rd_q    <= mem_q[rd_addr];
      last_q  <= rd_last;
      trunc_q <= dtrunc_q[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  assign valid_o           = ov_q;
  assign token_byte_o      = rd_q;
  assign token_last_o      = last_q;
  assign token_truncated_o = trunc_q;
endmodule

// File: rtl/core/text_tokenizer_stopword_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_tokenizer_stopword_filter
// Lowercasing byte tokenizer that drops English stop words.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle, and token bytes leave one per cycle while
// the output is ready. The front gathers a token into one of two buffer banks
// while the back emits a finished token from the other bank, so input stalls
// only while two finished tokens are held for the output. When the closing
// byte of a kept token is accepted its descriptor is queued; its first
// byte is then registered and offered; the rest follow while output is ready.
module text_tokenizer_stopword_filter #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  tts_in_if.sink   in_if,
  tts_out_if.source out_if
);
  tts_pkg::buf_wr_t wr;
  logic             full;

  tts_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_if.valid),
    .text_byte_i   (in_if.text_byte),
    .end_of_text_i (in_if.end_of_text),
    .full_i        (full),
    .ready_o       (in_if.ready),
    .wr_o          (wr)
  );

  tts_back #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (wr),
    .full_o            (full),
    .ready_i           (out_if.ready),
    .valid_o           (out_if.valid),
    .token_byte_o      (out_if.token_byte),
    .token_last_o      (out_if.token_last),
    .token_truncated_o (out_if.token_truncated)
  );
endmodule

// File: rtl/core/tts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the token output channel.
// ----------------------------------------------------------------------------
module tts_checker #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] token_byte_i,
  input logic       token_last_i,
  input logic       token_truncated_i
);
  localparam int CW = $clog2(MAX_TOKEN_LEN + 1);

  logic [CW-1:0] pos_q;
  logic          tr_q;
  logic          acc;

  assign acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tr_q  <= 1'b0;
    end else if (acc) begin
      pos_q <= token_last_i ? '0 : pos_q + CW'(1);
      tr_q  <= token_truncated_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_byte_i) &&
    $stable(token_last_i)) else $error("stalled output changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i) else $error("output valid during reset");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && pos_q == CW'(MAX_TOKEN_LEN - 1) |-> token_last_i)
    else $error("token longer than the buffer");

  a_trunc_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && pos_q != '0 |-> token_truncated_i == tr_q)
    else $error("truncated flag changed within a token");
endmodule

bind text_tokenizer_stopword_filter tts_checker #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .token_byte_i      (out_if.token_byte),
  .token_last_i      (out_if.token_last),
  .token_truncated_i (out_if.token_truncated)
);

// File: verif/tb_text_tokenizer_stopword_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_tokenizer_stopword_filter
// Self-checking testbench for the tokenizer with stop-word filter.
// ----------------------------------------------------------------------------
// Text bytes are sent over the input channel while a predictor rebuilds the
// tokens, drops stop words and queues the expected token bytes. A checker
// compares every token byte leaving the block with the oldest expected one.
// Directed texts cover byte classes, stop words, overlong tokens and empty
// tokens; random texts follow with varying idle patterns on both sides.
module tb_text_tokenizer_stopword_filter;

  localparam int MAX_LEN  = 32;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } token_beat_t;

  logic clk_i;
  logic rst_ni;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  text_tokenizer_stopword_filter #(
    .MAX_TOKEN_LEN(MAX_LEN)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  token_beat_t expected_beats[$];
  logic [7:0]  tok_buf[MAX_LEN];
  int          tok_len;
  logic        tok_over;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          n_errors = 0;
  int          n_sent;
  int          n_checked = 0;
  int          wdog = 0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit token_is_stop();
    logic [3:0] l;
    bit         same;
    if (tok_over) return 1'b0;
    for (int k = 0; k < tts_pkg::STOP_COUNT; k++) begin
      l = tts_pkg::stop_len(k);
      if (int'(l) == tok_len) begin
        same = 1'b1;
        for (int j = 0; j < tok_len; j++) begin
          if (tts_pkg::stop_char(k, tts_pkg::LEN_W'(j)) != tok_buf[j]) same = 1'b0;
        end
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_byte(input logic [7:0] c, input logic eot);
    logic [7:0]  v;
    bit          is_tok;
    token_beat_t b;
    v      = c;
    is_tok = 1'b0;
    if (c >= 8'h80) begin
      is_tok = 1'b1;
    end else if (c >= "A" && c <= "Z") begin
      v      = c + 8'd32;
      is_tok = 1'b1;
    end else if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
      is_tok = 1'b1;
    end
    if (is_tok) begin
      if (tok_len < MAX_LEN) begin
        tok_buf[tok_len] = v;
        tok_len++;
      end else begin
        tok_over = 1'b1;
      end
    end
    if (!is_tok || eot) begin
      if (tok_len > 0 && !token_is_stop()) begin
        for (int i = 0; i < tok_len; i++) begin
          b.data  = tok_buf[i];
          b.last  = (i + 1 == tok_len);
          b.trunc = tok_over;
          expected_beats = {expected_beats, b};
        end
      end
      tok_len  = 0;
      tok_over = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= c;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_byte(c, eot);
    n_sent++;
  endtask

  task automatic send_text(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    token_beat_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_checked++;
      if (expected_beats.size() == 0) begin
        $error("unexpected token byte %h", out_if.token_byte);
        n_errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_if.token_byte !== e.data) begin
          $error("token_byte: expected %h, actual %h", e.data, out_if.token_byte);
          n_errors++;
        end
        if (out_if.token_last !== e.last) begin
          $error("token_last: expected %b, actual %b", e.last, out_if.token_last);
          n_errors++;
        end
        if (out_if.token_truncated !== e.trunc) begin
          $error("token_truncated: expected %b, actual %b", e.trunc,
                 out_if.token_truncated);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
    end
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired, %0d token bytes outstanding", expected_beats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_byte_classes();
    send_text("AZaz09", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h2F, 1'b0);
    send_byte(8'h3A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_stop_words();
    send_text("The cat Yourselves ourselves themselves dogs a i ", 1'b0);
    send_text("thee th yourselvesx", 1'b1);
  endtask

  task automatic test_overlong();
    for (int i = 0; i < MAX_LEN + 5; i++) send_byte(8'(8'h61 + i % 26), 1'b0);
    send_byte(" ", 1'b0);
    for (int i = 0; i < MAX_LEN; i++) send_byte("Q", 1'b0);
    send_byte(".", 1'b0);
    for (int i = 0; i < MAX_LEN + 1; i++) send_byte("b", i == MAX_LEN);
  endtask

  task automatic test_empty_and_flush();
    send_text("  ,,", 1'b1);
    send_byte(" ", 1'b1);
    send_text("x", 1'b1);
    send_text("the", 1'b1);
  endtask

  task automatic send_random_word();
    int    k;
    int    n;
    logic [3:0] l;
    case ($urandom_range(9))
      0, 1, 2: begin
        k = $urandom_range(tts_pkg::STOP_COUNT - 1);
        l = tts_pkg::stop_len(k);
        for (int j = 0; j < int'(l); j++) begin
          logic [7:0] c;
          c = tts_pkg::stop_char(k, tts_pkg::LEN_W'(j));
          if ($urandom_range(1)) c = c - 8'd32;
          send_byte(c, 1'b0);
        end
      end
      3: begin
        n = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
        for (int j = 0; j < n; j++) send_byte(8'($urandom_range(128, 255)), 1'b0);
      end
      4: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      default: begin
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(3))
            0: send_byte(8'($urandom_range("a", "z")), 1'b0);
            1: send_byte(8'($urandom_range("A", "Z")), 1'b0);
            2: send_byte(8'($urandom_range("0", "9")), 1'b0);
            default: send_byte(8'($urandom_range(128, 255)), 1'b0);
          endcase
        end
      end
    endcase
    if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)), 1'b1);
    else send_byte(8'($urandom_range(0, 47)), 1'b0);
  endtask

  task automatic test_random(input int n_bytes);
    int target;
    target = n_sent + n_bytes;
    while (n_sent < target) send_random_word();
  endtask

  initial begin
    n_sent        = 0;
    tok_len       = 0;
    tok_over      = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 85;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.text_byte    = 8'h00;
    in_if.end_of_text  = 1'b0;
    out_if.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_byte_classes();
    test_stop_words();
    wait_drained();
    test_overlong();
    test_empty_and_flush();
    test_random(75);
    wait_drained();
    send_idle_pct = 85;
    recv_idle_pct = 35;
    test_random(75);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(75);
    send_byte(" ", 1'b1);

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d text bytes and checked %0d token bytes, covering stop words,",
             n_sent, n_checked);
    $display("overlong tokens, empty tokens and flushes under varied back-pressure.");
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tts_pkg.sv
rtl/core/tts_if.sv
rtl/core/tts_front.sv
rtl/core/tts_back.sv
rtl/core/text_tokenizer_stopword_filter.sv
rtl/core/tts_checker.sv
verif/tb_text_tokenizer_stopword_filter.sv
